// ===== rtl/core/tmm_pkg.sv =====
// Shared constants, field widths and controller/datapath interface types for the melody matcher.
package tmm_pkg;

	// Store depths.
	localparam int PATTERN_DEPTH = 256;
	localparam int TEXT_DEPTH = 4096;

	// Address and count widths derived from the store depths.
	localparam int PAT_AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int TEXT_AW = $clog2(TEXT_DEPTH);
	localparam int PCNT_W = $clog2(PATTERN_DEPTH + 1);
	localparam int TCNT_W = $clog2(TEXT_DEPTH + 1);
	localparam int CMP_W = (PCNT_W > TCNT_W) ? PCNT_W : TCNT_W;

	// Field widths of the words on the two channels.
	localparam int NOTE_W = 7;
	localparam int TIME_W = 32;
	localparam int IDX_W = 12;
	localparam int DIFF_W = NOTE_W + 1;
	localparam int IN_DATA_W = 40;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_PAD_W = OUT_DATA_W - IDX_W - 2;

	// Element kinds carried in tuser bit 0.
	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_start;
		logic rd_init;
		logic first_ev;
		logic step;
		logic next_start;
		logic done_ld;
	} tmm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic hit;
		logic miss;
		logic last_start;
		logic out_free;
	} tmm_stat_t;

endpackage

// ===== rtl/core/transposed_melody_match.sv =====
// Top level of the transposition-invariant melody matcher.
// The block takes pattern notes and time-sorted text events as words on the slave stream,
// one word per cycle while it is idle, and stores up to 256 pattern notes and 4096 text
// events. A text word with tlast set ends the text and starts a search for the first start
// index where the pattern, shifted by one constant transposition, occurs; notes that share
// a time stamp form a chord, and any one note of a chord may supply the next pattern note.
// The search walks the text one position per cycle in a single shared comparator, reading
// the text store and the pattern store once per cycle. Each start index first passes the
// setup states INIT and FIRST and then visits text positions one at a time; a search goes
// straight to the result, with no walk, when the pattern is empty or longer than the text.
// While a search runs the slave stream is held off; loading resumes as soon as the result
// is in the output register, even when the master side has not yet taken it. The result
// word carries the match flag, the start index (zero without a match) and an overflow flag
// that is set when a store was full and elements were dropped since the previous result.
module transposed_melody_match (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: event_time [31:0], note [38:32], zero [39]
	input  logic [tmm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// tuser: kind [0], first [1]
	input  logic [tmm_pkg::IN_USER_W-1:0]       s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: matched [0], start_index [12:1], overflow [13], zero [15:14]
	output logic [tmm_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	tmm_pkg::tmm_cmd_t  cmd;
	tmm_pkg::tmm_stat_t stat;

	// The controller sequences loading, the per-start walk and the result hand-off.
	tmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser[0]),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds both stores, the counts, the walk registers and the result word.
	tmm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== rtl/core/tmm_ctrl.sv =====
// Controller state machine that sequences loading, the search walk and result hand-off.
module tmm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	input  logic               in_last,
	output logic               in_ready,
	input  tmm_pkg::tmm_stat_t stat,
	output tmm_pkg::tmm_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_FIRST = 3'd3;
	localparam logic [2:0] ST_EVAL  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && (in_kind == tmm_pkg::KIND_TEXT) && in_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.clr_start = 1'b1;
				state_d = stat.empty ? ST_DONE : ST_INIT;
			end
			ST_INIT: begin
				cmd.rd_init = 1'b1;
				state_d = ST_FIRST;
			end
			ST_FIRST: begin
				cmd.first_ev = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.step = 1'b1;
				if (stat.hit) begin
					state_d = ST_DONE;
				end else if (stat.miss) begin
					if (stat.last_start) begin
						state_d = ST_DONE;
					end else begin
						cmd.next_start = 1'b1;
						state_d = ST_INIT;
					end
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.done_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/tmm_dp.sv =====
// Datapath: pattern and text stores, element counters, search walk registers and result register.
module tmm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmm_pkg::tmm_cmd_t                   cmd,
	output tmm_pkg::tmm_stat_t                  stat,
	input  logic [tmm_pkg::IN_DATA_W-1:0]       in_data,
	input  logic [tmm_pkg::IN_USER_W-1:0]       in_user,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tmm_pkg::OUT_DATA_W-1:0]      out_data
);

	// Each text entry holds the note and a flag that is set when its time
	// equals the time of the entry before it.
	logic [tmm_pkg::NOTE_W:0]    text_mem [tmm_pkg::TEXT_DEPTH];
	logic [tmm_pkg::NOTE_W-1:0]  pat_mem [tmm_pkg::PATTERN_DEPTH];

	logic [tmm_pkg::NOTE_W:0]    text_rd_q;
	logic [tmm_pkg::NOTE_W-1:0]  pat_rd_q;
	logic [tmm_pkg::TEXT_AW-1:0] text_raddr;
	logic [tmm_pkg::PAT_AW-1:0]  pat_raddr;

	logic [tmm_pkg::PCNT_W-1:0]  pcount_q;
	logic [tmm_pkg::TCNT_W-1:0]  tcount_q;
	logic                        overflow_q;
	logic [tmm_pkg::TIME_W-1:0]  last_time_q;

	logic [tmm_pkg::TEXT_AW-1:0] i_q;
	logic [tmm_pkg::TEXT_AW-1:0] pos_q;
	logic [tmm_pkg::PCNT_W-1:0]  j_q;
	logic [tmm_pkg::DIFF_W-1:0]  shift_q;
	logic [tmm_pkg::NOTE_W-1:0]  note_cur_q;
	logic                        skip_q;
	logic                        found_q;

	logic                        out_valid_q;
	logic                        out_matched_q;
	logic [tmm_pkg::IDX_W-1:0]   out_index_q;
	logic                        out_over_q;

	logic                        in_kind;
	logic                        in_first;
	logic [tmm_pkg::TIME_W-1:0]  in_time;
	logic [tmm_pkg::NOTE_W-1:0]  in_note;
	logic [tmm_pkg::PCNT_W-1:0]  p_eff;
	logic [tmm_pkg::TCNT_W-1:0]  t_eff;
	logic                        p_ok;
	logic                        t_ok;
	logic                        same_prev;
	logic                        pat_wr;
	logic                        text_wr;

	logic [tmm_pkg::TCNT_W-1:0]  pos_inc;
	logic                        more;
	logic                        chord;
	logic [tmm_pkg::NOTE_W-1:0]  note_nx;
	logic [tmm_pkg::DIFF_W-1:0]  diff;
	logic                        seek_hit;
	logic                        took;
	logic [tmm_pkg::PCNT_W-1:0]  j_nx;
	logic                        hit;
	logic                        miss;
	logic                        advance;

	assign in_kind  = in_user[0];
	assign in_first = in_user[1];
	assign in_time  = in_data[tmm_pkg::TIME_W-1:0];
	assign in_note  = in_data[tmm_pkg::TIME_W +: tmm_pkg::NOTE_W];

	// Load side: a first element restarts its sequence before it is stored.
	assign p_eff = in_first ? '0 : pcount_q;
	assign t_eff = in_first ? '0 : tcount_q;
	assign p_ok = p_eff < tmm_pkg::PCNT_W'(tmm_pkg::PATTERN_DEPTH);
	assign t_ok = t_eff < tmm_pkg::TCNT_W'(tmm_pkg::TEXT_DEPTH);
	assign same_prev = (t_eff != '0) && (in_time == last_time_q);
	assign pat_wr = cmd.load && (in_kind == tmm_pkg::KIND_PATTERN) && p_ok;
	assign text_wr = cmd.load && (in_kind == tmm_pkg::KIND_TEXT) && t_ok;

	// One walk step at text position pos_q; the registered read holds entry pos_q + 1.
	assign pos_inc = tmm_pkg::TCNT_W'(pos_q) + tmm_pkg::TCNT_W'(1);
	assign more = pos_inc < tcount_q;
	assign chord = more && text_rd_q[0];
	assign note_nx = text_rd_q[tmm_pkg::NOTE_W:1];
	assign diff = {1'b0, pat_rd_q} - {1'b0, note_cur_q};
	assign seek_hit = !skip_q && (diff == shift_q);
	assign took = skip_q || seek_hit;
	assign j_nx = j_q + tmm_pkg::PCNT_W'(seek_hit);
	assign hit = took && !chord && (j_nx == pcount_q);
	assign miss = took ? (!chord && (j_nx != pcount_q) && !more) : !chord;
	assign advance = cmd.step && !hit && !miss;

	// Read addresses follow the values the walk registers take at this edge.
	always_comb begin
		text_raddr = i_q;
		pat_raddr = '0;
		if (cmd.first_ev) begin
			text_raddr = i_q + tmm_pkg::TEXT_AW'(1);
			pat_raddr = tmm_pkg::PAT_AW'(1);
		end else if (cmd.step) begin
			text_raddr = pos_q + tmm_pkg::TEXT_AW'(2);
			pat_raddr = j_nx[tmm_pkg::PAT_AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (text_wr) begin
			text_mem[t_eff[tmm_pkg::TEXT_AW-1:0]] <= {in_note, same_prev};
		end
		text_rd_q <= text_mem[text_raddr];
	end

	always_ff @(posedge clk) begin
		if (pat_wr) begin
			pat_mem[p_eff[tmm_pkg::PAT_AW-1:0]] <= in_note;
		end
		pat_rd_q <= pat_mem[pat_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			tcount_q <= '0;
			overflow_q <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (in_kind == tmm_pkg::KIND_PATTERN) begin
					if (p_ok) begin
						pcount_q <= p_eff + tmm_pkg::PCNT_W'(1);
					end else begin
						pcount_q <= p_eff;
						overflow_q <= 1'b1;
					end
				end else begin
					if (t_ok) begin
						tcount_q <= t_eff + tmm_pkg::TCNT_W'(1);
					end else begin
						tcount_q <= t_eff;
						overflow_q <= 1'b1;
					end
				end
			end
			if (cmd.clr_start) begin
				found_q <= 1'b0;
			end else if (cmd.step && hit) begin
				found_q <= 1'b1;
			end
			if (cmd.done_ld) begin
				overflow_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_wr) begin
			last_time_q <= in_time;
		end
		if (cmd.clr_start) begin
			i_q <= '0;
		end else if (cmd.next_start) begin
			i_q <= i_q + tmm_pkg::TEXT_AW'(1);
		end
		if (cmd.first_ev) begin
			shift_q <= {1'b0, pat_rd_q} - {1'b0, text_rd_q[tmm_pkg::NOTE_W:1]};
			note_cur_q <= text_rd_q[tmm_pkg::NOTE_W:1];
			pos_q <= i_q;
			j_q <= tmm_pkg::PCNT_W'(1);
			skip_q <= 1'b1;
		end else if (advance) begin
			note_cur_q <= note_nx;
			pos_q <= pos_q + tmm_pkg::TEXT_AW'(1);
			j_q <= j_nx;
			skip_q <= took && chord;
		end
		if (cmd.done_ld) begin
			out_matched_q <= found_q;
			out_index_q <= found_q ? tmm_pkg::IDX_W'(i_q) : '0;
			out_over_q <= overflow_q;
		end
	end

	assign stat.empty = (pcount_q == '0)
		|| (tmm_pkg::CMP_W'(pcount_q) > tmm_pkg::CMP_W'(tcount_q));
	assign stat.hit = hit;
	assign stat.miss = miss;
	assign stat.last_start = tmm_pkg::CMP_W'(i_q)
		== (tmm_pkg::CMP_W'(tcount_q) - tmm_pkg::CMP_W'(pcount_q));
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data = {{tmm_pkg::OUT_PAD_W{1'b0}}, out_over_q, out_index_q, out_matched_q};

	// A step ends either in a hit or a miss, never both.
	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !(hit && miss))
		else $error("walk step reports both hit and miss");

	// The walk never stands on a position outside the loaded text.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (tmm_pkg::TCNT_W'(pos_q) < tcount_q))
		else $error("walk position beyond text count");

	// A step that neither hits nor misses moves exactly one position on.
	a_pos_adv: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (pos_q == $past(pos_q) + tmm_pkg::TEXT_AW'(1)))
		else $error("walk position did not advance by one");

	// A result is only loaded when the output register can take it.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done_ld |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending word");

endmodule
